[rtl/core/hclt_pkg.sv]
package hclt_pkg;

  localparam int unsigned SymW = 16;
  localparam int unsigned CodeW = 16;
  localparam int unsigned WidthW = 5;
  localparam int unsigned MaxWidthDefault = 16;

  localparam logic [SymW-1:0] MaxSymbols = 16'd512;
  localparam logic [SymW-1:0] EmptyEntry = 16'hFFFF;

  typedef enum logic [1:0] {
    OpClear  = 2'd0,
    OpInsert = 2'd1,
    OpLookup = 2'd2
  } op_e;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage

[rtl/core/huffman_code_lookup_table_core.sv]
// Huffman decode table with one sub-table per code length, held in a single-port
// synchronous memory of 2^(MAX_WIDTH+1) entries. After reset, and after every clear
// request, the block sweeps the whole memory one entry per cycle and accepts no request
// until the sweep is done; the result of a clear request is offered at the start of the
// sweep. Inserts, and lookups that need no table read, leave the block idle, so requests
// can follow back to back while the output is taken. A lookup that reads the table goes
// through StLook, which moves the registered read data of the memory into the output
// register. A pending result that is not taken holds off the next request.
module huffman_code_lookup_table_core #(
  parameter int unsigned MAX_WIDTH = hclt_pkg::MaxWidthDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  operation_i,
  input  logic [hclt_pkg::SymW-1:0]   symbol_i,
  input  logic [hclt_pkg::CodeW-1:0]  code_i,
  input  logic [hclt_pkg::WidthW-1:0] code_len_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        found_o,
  output logic [hclt_pkg::SymW-1:0]   symbol_out_o,
  output logic                        bad_request_o
);
  import hclt_pkg::*;

  localparam int unsigned AddrW = MAX_WIDTH + 1;

  mem_ctl_t         mem_ctl;
  logic [AddrW-1:0] mem_addr;
  logic [SymW-1:0]  mem_wdata;
  logic [SymW-1:0]  mem_rdata;

  hclt_ctrl #(
    .MaxWidth (MAX_WIDTH),
    .AddrW    (AddrW)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .operation_i   (operation_i),
    .symbol_i      (symbol_i),
    .code_i        (code_i),
    .code_len_i    (code_len_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .found_o       (found_o),
    .symbol_out_o  (symbol_out_o),
    .bad_request_o (bad_request_o),
    .mem_ctl_o     (mem_ctl),
    .mem_addr_o    (mem_addr),
    .mem_wdata_o   (mem_wdata),
    .mem_rdata_i   (mem_rdata)
  );

  hclt_mem #(
    .AddrW (AddrW)
  ) u_mem (
    .clk_i   (clk_i),
    .ctl_i   (mem_ctl),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

endmodule

[rtl/core/hclt_mem.sv]
module hclt_mem #(
  parameter int unsigned AddrW = hclt_pkg::MaxWidthDefault + 1
) (
  input  logic                     clk_i,
  input  hclt_pkg::mem_ctl_t       ctl_i,
  input  logic [AddrW-1:0]         addr_i,
  input  logic [hclt_pkg::SymW-1:0] wdata_i,
  output logic [hclt_pkg::SymW-1:0] rdata_o
);
  import hclt_pkg::*;

  localparam int unsigned Depth = 1 << AddrW;

  logic [SymW-1:0] mem_q [Depth];
  logic [SymW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (ctl_i.rd_en) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/hclt_ctrl.sv]
module hclt_ctrl #(
  parameter int unsigned MaxWidth = hclt_pkg::MaxWidthDefault,
  parameter int unsigned AddrW    = MaxWidth + 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  operation_i,
  input  logic [hclt_pkg::SymW-1:0]   symbol_i,
  input  logic [hclt_pkg::CodeW-1:0]  code_i,
  input  logic [hclt_pkg::WidthW-1:0] code_len_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        found_o,
  output logic [hclt_pkg::SymW-1:0]   symbol_out_o,
  output logic                        bad_request_o,
  output hclt_pkg::mem_ctl_t          mem_ctl_o,
  output logic [AddrW-1:0]            mem_addr_o,
  output logic [hclt_pkg::SymW-1:0]   mem_wdata_o,
  input  logic [hclt_pkg::SymW-1:0]   mem_rdata_i
);
  import hclt_pkg::*;

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StClear = 2'd1;
  localparam logic [1:0] StLook  = 2'd2;

  localparam logic [WidthW-1:0] MaxWidthW = WidthW'(MaxWidth);
  localparam logic [AddrW-1:0] LastAddr = '1;

  logic [1:0]        state_q, state_d;
  logic [AddrW-1:0]  clr_addr_q, clr_addr_d;
  logic [WidthW-1:0] longest_q, longest_d;
  logic              eq_q, eq_d;
  logic              out_valid_q, out_valid_d;
  logic              found_q, found_d;
  logic [SymW-1:0]   sym_q, sym_d;
  logic              bad_q, bad_d;

  logic              accept;
  logic [AddrW-1:0]  one_w;
  logic [AddrW-1:0]  req_addr;

  assign in_ready_o = (state_q == StIdle) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  assign one_w    = AddrW'(1) << code_len_i;
  assign req_addr = one_w - AddrW'(2) + (AddrW'(code_i) & (one_w - AddrW'(1)));

  always_comb begin
    state_d     = state_q;
    clr_addr_d  = clr_addr_q;
    longest_d   = longest_q;
    eq_d        = eq_q;
    out_valid_d = out_valid_q && !out_ready_i;
    found_d     = found_q;
    sym_d       = sym_q;
    bad_d       = bad_q;
    mem_ctl_o   = '0;
    mem_addr_o  = req_addr;
    mem_wdata_o = symbol_i;

    case (state_q)
      StClear: begin
        mem_ctl_o.wr_en = 1'b1;
        mem_addr_o      = clr_addr_q;
        mem_wdata_o     = EmptyEntry;
        clr_addr_d      = clr_addr_q + AddrW'(1);
        if (clr_addr_q == LastAddr) begin
          state_d = StIdle;
        end
      end
      StLook: begin
        out_valid_d = 1'b1;
        bad_d       = 1'b0;
        state_d     = StIdle;
        if (mem_rdata_i == EmptyEntry) begin
          found_d = eq_q;
          sym_d   = EmptyEntry;
        end else begin
          found_d = 1'b1;
          sym_d   = mem_rdata_i;
        end
      end
      StIdle: begin
        if (accept) begin
          case (operation_i)
            OpClear: begin
              out_valid_d = 1'b1;
              found_d     = 1'b0;
              sym_d       = '0;
              bad_d       = 1'b0;
              longest_d   = '0;
              clr_addr_d  = '0;
              state_d     = StClear;
            end
            OpInsert: begin
              out_valid_d = 1'b1;
              found_d     = 1'b0;
              sym_d       = '0;
              bad_d       = 1'b0;
              if (code_len_i != '0) begin
                if (symbol_i >= MaxSymbols || code_len_i > MaxWidthW) begin
                  bad_d = 1'b1;
                end else begin
                  mem_ctl_o.wr_en = 1'b1;
                  if (code_len_i > longest_q) begin
                    longest_d = code_len_i;
                  end
                end
              end
            end
            OpLookup: begin
              if (code_len_i == '0) begin
                out_valid_d = 1'b1;
                found_d     = 1'b0;
                sym_d       = EmptyEntry;
                bad_d       = 1'b1;
              end else if (code_len_i > longest_q) begin
                out_valid_d = 1'b1;
                found_d     = 1'b1;
                sym_d       = EmptyEntry;
                bad_d       = 1'b0;
              end else begin
                mem_ctl_o.rd_en = 1'b1;
                eq_d            = (code_len_i == longest_q);
                state_d         = StLook;
              end
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      clr_addr_q  <= '0;
      longest_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_addr_q  <= clr_addr_d;
      longest_q   <= longest_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    eq_q    <= eq_d;
    found_q <= found_d;
    sym_q   <= sym_d;
    bad_q   <= bad_d;
  end

  assign out_valid_o   = out_valid_q;
  assign found_o       = found_q;
  assign symbol_out_o  = sym_q;
  assign bad_request_o = bad_q;

  a_look_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StLook |-> $past(mem_ctl_o.rd_en))
    else $error("Lookup state entered without a table read.");

  a_look_output_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StLook |-> !out_valid_q)
    else $error("Lookup result would overwrite a pending result.");

  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StClear |-> !in_ready_o && mem_ctl_o.wr_en)
    else $error("Clear sweep interrupted.");

  a_longest_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    longest_q <= MaxWidthW)
    else $error("Longest code length exceeds the table.");

endmodule
